[rtl/hsl2rgb_pkg.sv]
// Shared types and constants for the HSL to RGB converter.
package hsl2rgb_pkg;

    // Output channel width and its largest value.
    localparam int CHAN_BITS = 8;

    typedef logic [CHAN_BITS-1:0] chan_byte_t;

    localparam chan_byte_t BYTE_MAX = '1;

    // Channel lanes in the datapath.
    localparam int NUM_CHAN = 3;
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

endpackage

[rtl/hsl_to_rgb_converter.sv]
// HSL to RGB pixel converter: a five-stage pipeline with per-stage flow control.
//
// Takes one HSL pixel per clock cycle unless in_stall holds it off and returns its
// 8-bit RGB value; the five register stages are clamp and hue thirds with the S*L
// multiply, the two helper levels with the per-channel hue weights, the
// per-channel level multiplies, the level sums, and the scaling by 255 into the
// output register. Hue is a wrapping fraction of FRAC_BITS bits; saturation and
// lightness are fractions where 2^FRAC_BITS means 1.0 and larger values clamp to
// 1.0. All arithmetic is exact until the final truncation of 255 times the level.
// Each stage carries its own valid bit and a stage loads whenever it is empty or
// its contents move on, so bubbles close up and a held result at the output
// does not stop the pipeline from taking items until every stage is full.
module hsl_to_rgb_converter #(
    parameter int FRAC_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FRAC_BITS-1:0]   hue,
    input  logic [FRAC_BITS:0]     saturation,
    input  logic [FRAC_BITS:0]     lightness,
    output logic                   out_valid,
    input  logic                   out_stall,
    output hsl2rgb_pkg::chan_byte_t red,
    output hsl2rgb_pkg::chan_byte_t green,
    output hsl2rgb_pkg::chan_byte_t blue
);

    localparam int STAGES = 5;
    localparam int NC     = hsl2rgb_pkg::NUM_CHAN;
    localparam int CB     = hsl2rgb_pkg::CHAN_BITS;
    localparam int SW     = FRAC_BITS + 1;      // saturation, lightness
    localparam int HW     = FRAC_BITS + 2;      // hue in units of 1/(3F)
    localparam int LVW    = 2 * FRAC_BITS + 1;  // levels in units of 1/F^2
    localparam int W2     = 2 * FRAC_BITS + 2;  // level intermediates
    localparam int MW     = FRAC_BITS + 1;      // hue weight, at most F
    localparam int PW     = LVW + MW;           // full product width
    localparam int CW     = 3 * FRAC_BITS + 1;  // channel level, units 1/F^3
    localparam int SCW    = CW + CB;            // level times 255

    localparam logic [SW-1:0] ONE_S      = SW'(1) << FRAC_BITS;
    localparam logic [SW-1:0] HALF_S     = SW'(1) << (FRAC_BITS - 1);
    localparam logic [HW-1:0] F_H        = HW'(1) << FRAC_BITS;
    localparam logic [HW-1:0] F2_H       = HW'(2) << FRAC_BITS;
    localparam logic [HW-1:0] HALF_H     = HW'(1) << (FRAC_BITS - 1);
    localparam logic [HW-1:0] THREEHLF_H = F_H + HALF_H;
    localparam logic [MW-1:0] F_M        = MW'(1) << FRAC_BITS;

    // Weight of the level difference for a hue position: rising edge,
    // plateau at the high level, falling edge, or the low level.
    function automatic logic [MW-1:0] hue_weight(input logic [HW-1:0] h);
        logic [HW-1:0] rem;
        rem = F2_H - h;
        if (h < HALF_H)
            return MW'({h, 1'b0});
        else if (h < THREEHLF_H)
            return F_M;
        else if (h < F2_H)
            return MW'({rem, 1'b0});
        else
            return '0;
    endfunction

    // Flow control.
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] stg_ready;

    // A stage can load when it is empty or its item moves on.
    always_comb
    begin
        stg_ready[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stg_ready[k] = !valid_reg[k] || stg_ready[k+1];
        end
    end

    always_comb
    begin
        valid_next[0] = stg_ready[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = stg_ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_stall  = !stg_ready[0];
    assign out_valid = valid_reg[STAGES-1];

    // Stage 1: clamp inputs, form S*L and the three channel hue positions.
    logic [SW-1:0]   sat_c;
    logic [SW-1:0]   lit_c;
    logic [HW-1:0]   hue_g;
    logic [2*SW-1:0] sl_full;
    logic [SW-1:0]   sat1_reg, sat1_next;
    logic [SW-1:0]   lit1_reg, lit1_next;
    logic [LVW-1:0]  sl1_reg, sl1_next;
    logic [HW-1:0]   hue1_reg [NC];
    logic [HW-1:0]   hue1_next [NC];

    always_comb
    begin
        sat_c   = (saturation > ONE_S) ? ONE_S : saturation;
        lit_c   = (lightness > ONE_S) ? ONE_S : lightness;
        sl_full = (2*SW)'(sat_c) * (2*SW)'(lit_c);
        hue_g   = {2'b00, hue} + {1'b0, hue, 1'b0};

        sat1_next = sat_c;
        lit1_next = lit_c;
        sl1_next  = sl_full[LVW-1:0];
        hue1_next[hsl2rgb_pkg::CH_GREEN] = hue_g;
        hue1_next[hsl2rgb_pkg::CH_RED]   = (hue_g >= F2_H) ? hue_g - F2_H : hue_g + F_H;
        hue1_next[hsl2rgb_pkg::CH_BLUE]  = (hue_g >= F_H) ? hue_g - F_H : hue_g + F2_H;
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
        begin
            sat1_reg <= sat1_next;
            lit1_reg <= lit1_next;
            sl1_reg  <= sl1_next;
            hue1_reg <= hue1_next;
        end
    end

    // Stage 2: high and low levels, their difference, and the hue weights.
    logic [W2-1:0]  sum_ls;
    logic [W2-1:0]  hi_w;
    logic [W2-1:0]  lo_w;
    logic [LVW-1:0] lo2_reg, lo2_next;
    logic [LVW-1:0] d2_reg, d2_next;
    logic [MW-1:0]  wt2_reg [NC];
    logic [MW-1:0]  wt2_next [NC];

    always_comb
    begin
        sum_ls = W2'(lit1_reg) + W2'(sat1_reg);
        if (lit1_reg < HALF_S)
            hi_w = (W2'(lit1_reg) << FRAC_BITS) + W2'(sl1_reg);
        else
            hi_w = (sum_ls << FRAC_BITS) - W2'(sl1_reg);
        lo_w = (W2'(lit1_reg) << (FRAC_BITS + 1)) - hi_w;

        lo2_next = lo_w[LVW-1:0];
        d2_next  = hi_w[LVW-1:0] - lo_w[LVW-1:0];
        for (int c = 0; c < NC; c++)
        begin
            wt2_next[c] = hue_weight(hue1_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[1])
        begin
            lo2_reg <= lo2_next;
            d2_reg  <= d2_next;
            wt2_reg <= wt2_next;
        end
    end

    // Stage 3: weighted level difference for each channel.
    logic [PW-1:0]  prod_w [NC];
    logic [LVW-1:0] lo3_reg, lo3_next;
    logic [CW-1:0]  prod3_reg [NC];
    logic [CW-1:0]  prod3_next [NC];

    always_comb
    begin
        lo3_next = lo2_reg;
        for (int c = 0; c < NC; c++)
        begin
            prod_w[c]     = PW'(d2_reg) * PW'(wt2_reg[c]);
            prod3_next[c] = prod_w[c][CW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[2])
        begin
            lo3_reg   <= lo3_next;
            prod3_reg <= prod3_next;
        end
    end

    // Stage 4: channel level as low level plus the weighted difference.
    logic [CW-1:0] lvl4_reg [NC];
    logic [CW-1:0] lvl4_next [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            lvl4_next[c] = {lo3_reg, {FRAC_BITS{1'b0}}} + prod3_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[3])
            lvl4_reg <= lvl4_next;
    end

    // Stage 5: floor of 255 times the level, saturated to a byte.
    logic [SCW-1:0]           scaled [NC];
    logic [CB:0]              top_w [NC];
    hsl2rgb_pkg::chan_byte_t  rgb5_reg [NC];
    hsl2rgb_pkg::chan_byte_t  rgb5_next [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            scaled[c] = {lvl4_reg[c], {CB{1'b0}}} - SCW'(lvl4_reg[c]);
            top_w[c]  = scaled[c][SCW-1:3*FRAC_BITS];
            if (top_w[c] > {1'b0, hsl2rgb_pkg::BYTE_MAX})
                rgb5_next[c] = hsl2rgb_pkg::BYTE_MAX;
            else
                rgb5_next[c] = top_w[c][CB-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_ready[4])
            rgb5_reg <= rgb5_next;
    end

    assign red   = rgb5_reg[hsl2rgb_pkg::CH_RED];
    assign green = rgb5_reg[hsl2rgb_pkg::CH_GREEN];
    assign blue  = rgb5_reg[hsl2rgb_pkg::CH_BLUE];

endmodule

[rtl/hsl2rgb_checker.sv]
// Port-level checks for the HSL to RGB converter, bound to its top level.
module hsl2rgb_checker #(
    parameter int FRAC_BITS = 10
) (
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic [FRAC_BITS-1:0]    hue,
    input logic [FRAC_BITS:0]      saturation,
    input logic [FRAC_BITS:0]      lightness,
    input logic                    out_valid,
    input logic                    out_stall,
    input hsl2rgb_pkg::chan_byte_t red,
    input hsl2rgb_pkg::chan_byte_t green,
    input hsl2rgb_pkg::chan_byte_t blue
);

    // A result held by a stall keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
            && $stable(blue))
        else $error("held result changed under stall");

    // An empty output register means the pipeline can take an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output is empty");

    // An accepted item reaches the output when the output does not stall on the way.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
            ##1 !out_stall |=> out_valid)
        else $error("item did not reach the output in time");

    // Zero saturation gives a grey result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && saturation == '0) ##1 !out_stall ##1 !out_stall
            ##1 !out_stall ##1 !out_stall |=> red == green && green == blue)
        else $error("zero saturation did not give grey");

    // A result leaves only when it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid) |-> $past(!out_stall))
        else $error("result dropped without being taken");

endmodule

bind hsl_to_rgb_converter hsl2rgb_checker #(.FRAC_BITS(FRAC_BITS)) u_hsl2rgb_checker (.*);

[tb/tb_top.sv]
// Self-checking testbench for the HSL to RGB pixel converter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hsl2rgb_pkg::*;

    localparam int FRAC        = 10;
    localparam int ITEM_BLOCKS = 18;
    localparam int BLOCK_ITEMS = 50;
    localparam int CYCLE_LIMIT = 500000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic [FRAC-1:0] h;
        logic [FRAC:0]   s;
        logic [FRAC:0]   l;
    } hsl_t;

    typedef struct {
        hsl_t       pixel;
        chan_byte_t red;
        chan_byte_t green;
        chan_byte_t blue;
    } rgb_t;

    // Holds the expected colors of accepted pixels and checks results in order.
    class rgb_scoreboard;
        rgb_t expected_rgb[$];
        int   mismatches = 0;
        int   unexpected = 0;
        int   reported   = 0;
        int   checked    = 0;
        int   noted      = 0;
        int   greys      = 0;
        int   clamped    = 0;

        // Level of one channel at hue position x (units of 1/(3F)), in units of 1/F^3.
        function longint unsigned channel_level(longint unsigned lo, longint unsigned hi,
                                                longint unsigned x);
            longint unsigned f;
            longint unsigned d;
            f = 64'd1 << FRAC;
            d = hi - lo;
            if (2 * x < f)
                return lo * f + d * 2 * x;
            if (2 * x < 3 * f)
                return hi * f;
            if (x < 2 * f)
                return lo * f + d * 2 * (2 * f - x);
            return lo * f;
        endfunction

        // Truncates 255 times a level and saturates it to one byte.
        function chan_byte_t level_to_byte(longint unsigned level);
            longint unsigned v;
            v = (level * 255) >> (3 * FRAC);
            return (v > 255) ? BYTE_MAX : chan_byte_t'(v);
        endfunction

        // Works out the color that the converter must return for one pixel.
        function rgb_t predict_rgb(hsl_t px);
            rgb_t            c;
            longint unsigned f, s, l, hi, lo, hg, hr, hb;
            f = 64'd1 << FRAC;
            s = (px.s > f) ? f : px.s;
            l = (px.l > f) ? f : px.l;
            c.pixel = px;
            if (s == 0)
            begin
                c.red   = level_to_byte(l * (f * f));
                c.green = c.red;
                c.blue  = c.red;
                return c;
            end
            if (2 * l < f)
                hi = l * (f + s);
            else
                hi = (l + s) * f - s * l;
            lo = 2 * l * f - hi;
            hg = 3 * longint'(px.h);
            hr = hg + f;
            if (hr >= 3 * f)
                hr -= 3 * f;
            hb = hg + 2 * f;
            if (hb >= 3 * f)
                hb -= 3 * f;
            c.red   = level_to_byte(channel_level(lo, hi, hr));
            c.green = level_to_byte(channel_level(lo, hi, hg));
            c.blue  = level_to_byte(channel_level(lo, hi, hb));
            return c;
        endfunction

        // Records an accepted pixel and queues its expected color.
        function void note_pixel(hsl_t px);
            longint unsigned f;
            f = 64'd1 << FRAC;
            noted++;
            if (px.s == 0)
                greys++;
            if (px.s > f || px.l > f)
                clamped++;
            expected_rgb.push_back(predict_rgb(px));
        endfunction

        // Compares one output color with the oldest expectation.
        function void check_pixel(chan_byte_t r, chan_byte_t g, chan_byte_t b);
            rgb_t e;
            checked++;
            if (expected_rgb.size() == 0)
            begin
                unexpected++;
                if (reported < MAX_REPORTS)
                    $display("Unexpected output color %0d %0d %0d with no pixel pending",
                             r, g, b);
                reported++;
                return;
            end
            e = expected_rgb.pop_front();
            if (r !== e.red || g !== e.green || b !== e.blue)
            begin
                mismatches++;
                if (reported < MAX_REPORTS)
                    $display("Mismatch for h=%0d s=%0d l=%0d: expected %0d %0d %0d, got %0d %0d %0d",
                             e.pixel.h, e.pixel.s, e.pixel.l, e.red, e.green, e.blue,
                             r, g, b);
                reported++;
            end
        endfunction

        function int pending();
            return expected_rgb.size();
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    logic [FRAC-1:0] hue;
    logic [FRAC:0]   saturation;
    logic [FRAC:0]   lightness;
    logic            out_valid;
    logic            out_stall;
    chan_byte_t      red;
    chan_byte_t      green;
    chan_byte_t      blue;

    rgb_scoreboard   pixels = new();
    bit              steady_flow = 1'b0;
    int              cycles = 0;

    hsl_to_rgb_converter #(
        .FRAC_BITS (FRAC)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .hue        (hue),
        .saturation (saturation),
        .lightness  (lightness),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    always #5 clk = ~clk;

    // Every color leaving the converter is checked at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            pixels.check_pixel(red, green, blue);
    end

    // A run that does not finish in time is a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d colors outstanding",
                     cycles, pixels.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The output side stalls in random bursts, mostly short, some long.
    initial
    begin
        int r;
        int n;
        out_stall = 1'b0;
        forever
        begin
            r = $urandom_range(0, 99);
            if (steady_flow || r < 50)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                begin
                    @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            else
            begin
                if (r < 85)
                    n = $urandom_range(1, 3);
                else if (r < 95)
                    n = $urandom_range(4, 12);
                else
                    n = $urandom_range(20, 60);
                repeat (n)
                begin
                    @(negedge clk);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Presents one pixel and waits until the converter takes it.
    task automatic send_pixel(input hsl_t px);
        @(negedge clk);
        in_valid   <= 1'b1;
        hue        <= px.h;
        saturation <= px.s;
        lightness  <= px.l;
        do
            @(posedge clk);
        while (in_stall);
        pixels.note_pixel(px);
    endtask

    // Leaves the input idle for a number of cycles.
    task automatic hold_off(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // Gap after an item: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Saturation or lightness value: zero, full, above full, or in between.
    function automatic logic [FRAC:0] pick_fraction();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return (FRAC+1)'(1 << FRAC);
        if (r < 30)
            return (FRAC+1)'($urandom_range((1 << FRAC) + 1, (2 << FRAC) - 1));
        return (FRAC+1)'($urandom_range(1, (1 << FRAC) - 1));
    endfunction

    // Extremes, grey and clamp cases, and hues on and around the segment edges.
    hsl_t directed_pixels[24] = '{
        '{10'd0,    11'd0,    11'd0},
        '{10'd0,    11'd0,    11'd1024},
        '{10'd1023, 11'd0,    11'd2047},
        '{10'd0,    11'd1024, 11'd512},
        '{10'd0,    11'd1024, 11'd511},
        '{10'd170,  11'd1024, 11'd512},
        '{10'd171,  11'd1024, 11'd512},
        '{10'd341,  11'd1024, 11'd512},
        '{10'd342,  11'd1024, 11'd512},
        '{10'd512,  11'd1024, 11'd512},
        '{10'd682,  11'd1024, 11'd512},
        '{10'd683,  11'd1024, 11'd512},
        '{10'd853,  11'd1024, 11'd512},
        '{10'd854,  11'd1024, 11'd512},
        '{10'd1023, 11'd1024, 11'd512},
        '{10'd1,    11'd1,    11'd1},
        '{10'd256,  11'd2047, 11'd300},
        '{10'd600,  11'd700,  11'd2047},
        '{10'd900,  11'd1025, 11'd1025},
        '{10'd400,  11'd1024, 11'd1024},
        '{10'd100,  11'd1024, 11'd0},
        '{10'd777,  11'd512,  11'd768},
        '{10'd1023, 11'd2047, 11'd2047},
        '{10'd0,    11'd1,    11'd1023}
    };

    // Reset, directed pixels, random blocks, then drain and report.
    initial
    begin
        hsl_t px;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        hue        = '0;
        saturation = '0;
        lightness  = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_pixels[i])
        begin
            send_pixel(directed_pixels[i]);
            hold_off(pick_gap());
        end

        for (int blk = 0; blk < ITEM_BLOCKS; blk++)
        begin
            steady_flow = ($urandom_range(0, 3) == 0);
            // Halfway through, let the pipeline empty completely before going on.
            if (blk == ITEM_BLOCKS / 2)
            begin
                hold_off(1);
                while (pixels.pending() != 0)
                    @(posedge clk);
            end
            for (int k = 0; k < BLOCK_ITEMS; k++)
            begin
                px.h = FRAC'($urandom_range(0, (1 << FRAC) - 1));
                px.s = pick_fraction();
                px.l = pick_fraction();
                send_pixel(px);
                hold_off(pick_gap());
            end
        end
        steady_flow = 1'b0;
        hold_off(1);

        while (pixels.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Converted %0d pixels (%0d grey, %0d with saturation or lightness above one).",
                 pixels.noted, pixels.greys, pixels.clamped);
        $display("Checked %0d colors: %0d mismatches, %0d without a pixel pending.",
                 pixels.checked, pixels.mismatches, pixels.unexpected);
        if (pixels.mismatches == 0 && pixels.unexpected == 0 && pixels.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[hsl_to_rgb_converter.f]
rtl/hsl2rgb_pkg.sv
rtl/hsl_to_rgb_converter.sv
rtl/hsl2rgb_checker.sv
tb/tb_top.sv
